[design/itaf_pkg.sv]
// ----------------------------------------------------------------------------
// itaf_pkg
// Shared constants and helpers for the integer to ascii formatter: command
// codes, character codes and the hex digit to character mapping.
// ----------------------------------------------------------------------------
package itaf_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int IN_DATA_W       = 32;
  localparam int CMD_W           = 2;
  localparam int CHAR_W          = 8;
  localparam int COUNT_W         = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_SDEC = 2'd0,
    CMD_UDEC = 2'd1,
    CMD_HEXL = 2'd2,
    CMD_HEXU = 2'd3
  } cmd_t;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

  // ascii for one digit; decimal digits never exceed nine
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d,
                                                   input logic       upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + {4'b0000, d};
    end else begin
      digit_char = base + {4'b0000, d - 4'd10};
    end
  endfunction

endpackage

[design/integer_to_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Turns a value into its ascii text, signed or unsigned decimal or hex,
// most significant digit first, no leading zeros, with a running character
// count.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                               | tuser   | tlast
//  --------+-----------+-------------------------------------+---------+-------------
//  in_     | slave     | [31:0] value                        | command | -
//  out_    | master    | [7:0] character, [39:8] total_chars | -       | last char
//
//  decimal: an accept step, a double-dabble pass over VALUE_WIDTH bits (one bit
//  a cycle through the shared add-3 / shift unit), a pass that drops leading
//  zero digits, then the emit step, one character per cycle while the output
//  is not stalled, with a minus sign first when the value is negative.
//  hex: no conversion pass; output stalls hold the emit step in both modes.
//  in_tready is high only while idle; a waiting output transaction holds the
//  emit step but not the acceptance of the next input.
//  reset is synchronous and clears the character count; no clearing pass.
//
module integer_to_ascii_formatter
  import itaf_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [IN_DATA_W-1:0]        in_tdata,   // [31:0] value
  input  logic [CMD_W-1:0]            in_tuser,   // [1:0] command
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [CHAR_W+COUNT_W-1:0]   out_tdata,  // [7:0] character, [39:8] total_chars
  output logic                        out_tlast   // last character of the value
);

  localparam int NDIG     = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int DIG_BITS = 4 * NDIG;
  localparam int CNT_W    = $clog2(NDIG + 1);
  localparam int BIT_W    = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                 state_r;
  logic [VALUE_WIDTH-1:0] mag_r;
  logic [DIG_BITS-1:0]    dig_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [BIT_W-1:0]       bit_r;
  logic                   neg_r;
  logic                   hex_r;
  logic                   upper_r;
  logic [COUNT_W-1:0]     count_r;
  logic                   out_valid_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_last_r;

  logic [VALUE_WIDTH+IN_DATA_W-1:0] value_ext;
  logic [VALUE_WIDTH-1:0]           value_in;
  logic                             neg_nxt;
  logic [VALUE_WIDTH-1:0]           mag_nxt;
  logic [DIG_BITS-1:0]              dig_adj;
  logic [DIG_BITS-1:0]              dig_nxt;
  logic [3:0]                       top_dig;
  logic [COUNT_W-1:0]               count_nxt;
  logic                             out_free;
  logic                             in_fire;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {count_r, out_char_r};
  assign out_tlast  = out_last_r;
  assign top_dig    = dig_r[DIG_BITS-1 -: 4];
  assign count_nxt  = (count_r == {COUNT_W{1'b1}}) ? count_r : count_r + 1'b1;

  always_comb begin
    value_ext = {{VALUE_WIDTH{1'b0}}, in_tdata};
    value_in  = value_ext[VALUE_WIDTH-1:0];
    neg_nxt   = (in_tuser == CMD_SDEC) && value_in[VALUE_WIDTH-1];
    mag_nxt   = neg_nxt ? (~value_in + 1'b1) : value_in;
  end

  // double dabble: add three to every digit of five or more, then shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (dig_r[i*4 +: 4] >= 4'd5) begin
        dig_adj[i*4 +: 4] = dig_r[i*4 +: 4] + 4'd3;
      end else begin
        dig_adj[i*4 +: 4] = dig_r[i*4 +: 4];
      end
    end
    dig_nxt = {dig_adj[DIG_BITS-2:0], mag_r[VALUE_WIDTH-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
    end else begin
      // outside the emit step a taken transaction just empties the output
      if (out_tready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            neg_r   <= neg_nxt;
            hex_r   <= in_tuser[1];
            upper_r <= (in_tuser == CMD_HEXU);
            cnt_r   <= CNT_W'(NDIG);
            if (in_tuser[1]) begin
              dig_r   <= {{(DIG_BITS-VALUE_WIDTH){1'b0}}, mag_nxt};
              state_r <= ST_SKIP;
            end else begin
              mag_r   <= mag_nxt;
              dig_r   <= '0;
              bit_r   <= BIT_W'(VALUE_WIDTH - 1);
              state_r <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          dig_r <= dig_nxt;
          mag_r <= {mag_r[VALUE_WIDTH-2:0], 1'b0};
          bit_r <= bit_r - 1'b1;
          if (bit_r == '0) begin
            state_r <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // drop leading zero digits, keeping at least one
          if (cnt_r != CNT_W'(1) && top_dig == 4'd0) begin
            dig_r <= {dig_r[DIG_BITS-5:0], 4'd0};
            cnt_r <= cnt_r - 1'b1;
          end else begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            count_r     <= count_nxt;
            if (neg_r) begin
              out_char_r <= CHAR_MINUS;
              out_last_r <= 1'b0;
              neg_r      <= 1'b0;
            end else begin
              out_char_r <= hex_r ? digit_char(top_dig, upper_r)
                                  : (CHAR_ZERO | {4'b0000, top_dig});
              out_last_r <= (cnt_r == CNT_W'(1));
              dig_r      <= {dig_r[DIG_BITS-5:0], 4'd0};
              cnt_r      <= cnt_r - 1'b1;
              if (cnt_r == CNT_W'(1)) begin
                state_r <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // an accepted value keeps the input side busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted again straight after a transaction");

  // while a non-final character is offered, the run is still in progress
  a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !in_tready)
    else $error("input ready in the middle of a character run");

  // the character count never goes backwards
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r >= $past(count_r)))
    else $error("character count decreased");
`endif

endmodule
